/* sv/smwrr_pkg.sv */
// Package with the types, constants and helpers of the smooth weighted round-robin picker.
package smwrr_pkg;

  localparam int MAX_PEERS    = 16;
  localparam int NUM_CHANNELS = 4;
  localparam int MEM_DEPTH    = MAX_PEERS * NUM_CHANNELS;

  localparam int WEIGHT_W     = 14;
  localparam int CREDIT_W     = 19;
  localparam int TOTAL_W      = 18;
  localparam int CHANNEL_W    = 2;
  localparam int PEER_FIELD_W = 4;

  localparam int PEER_W = $clog2(MAX_PEERS);
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int CNT_W  = $clog2(MEM_DEPTH + 1);

  localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT = WEIGHT_W'(10000);

  localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
  localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [CHANNEL_W-1:0]    channel;
    logic [PEER_FIELD_W-1:0] peer_index;
    logic [WEIGHT_W-1:0]     weight;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic [PEER_FIELD_W-1:0] chosen_peer;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              clear_en;
    logic [ADDR_W-1:0] clr_addr;
    logic              load;
    logic              wr_weight;
    logic [PEER_W-1:0] rd_idx;
    logic              proc_en;
    logic [PEER_W-1:0] proc_idx;
    logic              op_scan;
    logic              op_sum;
    logic              finish;
    logic              store_total;
    logic              done;
  } ctl_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                  input logic [PEER_W-1:0] peer);
    return ADDR_W'(int'(ch) * MAX_PEERS + int'(peer));
  endfunction

endpackage

/* sv/smwrr_satadd.sv */
// Shared saturating adder for credits and channel totals.
module smwrr_satadd (
  input  logic signed [smwrr_pkg::CREDIT_W-1:0] a,
  input  logic signed [smwrr_pkg::CREDIT_W-1:0] b,
  output logic signed [smwrr_pkg::CREDIT_W-1:0] y
);

  logic signed [smwrr_pkg::CREDIT_W:0] sum;

  always_comb begin
    sum = {a[smwrr_pkg::CREDIT_W-1], a} + {b[smwrr_pkg::CREDIT_W-1], b};
    if (sum[smwrr_pkg::CREDIT_W] != sum[smwrr_pkg::CREDIT_W-1]) begin
      y = sum[smwrr_pkg::CREDIT_W] ? smwrr_pkg::CREDIT_MIN : smwrr_pkg::CREDIT_MAX;
    end else begin
      y = sum[smwrr_pkg::CREDIT_W-1:0];
    end
  end

endmodule

/* sv/smwrr_ctrl.sv */
// Sequencer that steps the clearing pass, weight writes, total sums and peer scans.
module smwrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  smwrr_pkg::req_t     req_data,
  input  logic                res_ready,
  output logic                req_ready,
  output logic                res_valid,
  output smwrr_pkg::ctl_t     ctl
);

  smwrr_pkg::state_t state, state_next;
  logic [smwrr_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [smwrr_pkg::CNT_W-1:0] cnt_dec;
  logic ch_ok, peer_ok, weight_ok, at_end, out_free;

  assign ch_ok     = int'(req_data.channel) < smwrr_pkg::NUM_CHANNELS;
  assign peer_ok   = int'(req_data.peer_index) < smwrr_pkg::MAX_PEERS;
  assign weight_ok = req_data.weight <= smwrr_pkg::WEIGHT_LIMIT;
  assign at_end    = cnt == smwrr_pkg::CNT_W'(smwrr_pkg::MAX_PEERS);
  assign out_free  = !res_valid || res_ready;
  assign cnt_dec   = cnt - smwrr_pkg::CNT_W'(1);

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    case (state)
      smwrr_pkg::ST_CLEAR: begin
        cnt_next = cnt + smwrr_pkg::CNT_W'(1);
        if (cnt == smwrr_pkg::CNT_W'(smwrr_pkg::MEM_DEPTH - 1)) begin
          state_next = smwrr_pkg::ST_IDLE;
          cnt_next   = '0;
        end
      end
      smwrr_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (!ch_ok) begin
            state_next = smwrr_pkg::ST_DONE;
          end else if (req_data.mode == smwrr_pkg::MODE_SELECT) begin
            state_next = smwrr_pkg::ST_SCAN;
          end else if (peer_ok && weight_ok) begin
            state_next = smwrr_pkg::ST_WRITE;
          end else begin
            state_next = smwrr_pkg::ST_DONE;
          end
        end
      end
      smwrr_pkg::ST_WRITE: begin
        state_next = smwrr_pkg::ST_SUM;
      end
      smwrr_pkg::ST_SUM: begin
        cnt_next = cnt + smwrr_pkg::CNT_W'(1);
        if (at_end) begin
          state_next = smwrr_pkg::ST_DONE;
          cnt_next   = '0;
        end
      end
      smwrr_pkg::ST_SCAN: begin
        cnt_next = cnt + smwrr_pkg::CNT_W'(1);
        if (at_end) begin
          state_next = smwrr_pkg::ST_FINISH;
          cnt_next   = '0;
        end
      end
      smwrr_pkg::ST_FINISH: begin
        state_next = smwrr_pkg::ST_DONE;
      end
      smwrr_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = smwrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smwrr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready       = state == smwrr_pkg::ST_IDLE;
    ctl             = '0;
    ctl.clr_addr    = cnt[smwrr_pkg::ADDR_W-1:0];
    ctl.rd_idx      = cnt[smwrr_pkg::PEER_W-1:0];
    ctl.proc_idx    = cnt_dec[smwrr_pkg::PEER_W-1:0];
    ctl.load        = req_ready && req_valid;
    case (state)
      smwrr_pkg::ST_CLEAR:  ctl.clear_en = 1'b1;
      smwrr_pkg::ST_WRITE:  ctl.wr_weight = 1'b1;
      smwrr_pkg::ST_SUM: begin
        ctl.op_sum      = 1'b1;
        ctl.proc_en     = cnt != '0;
        ctl.store_total = at_end;
      end
      smwrr_pkg::ST_SCAN: begin
        ctl.op_scan = 1'b1;
        ctl.proc_en = cnt != '0;
      end
      smwrr_pkg::ST_FINISH: ctl.finish = 1'b1;
      smwrr_pkg::ST_DONE:   ctl.done = out_free;
      default: ctl.load = ctl.load;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smwrr_pkg::ST_CLEAR;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (ctl.done) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/smwrr_datapath.sv */
// Weight and credit memories, channel totals, best-peer registers and the result register.
module smwrr_datapath (
  input  logic            clk,
  input  logic            rst,
  input  smwrr_pkg::req_t req_data,
  input  smwrr_pkg::ctl_t ctl,
  output smwrr_pkg::res_t res_data
);

  logic [smwrr_pkg::WEIGHT_W-1:0]        weight_mem [smwrr_pkg::MEM_DEPTH];
  logic signed [smwrr_pkg::CREDIT_W-1:0] credit_mem [smwrr_pkg::MEM_DEPTH];
  logic [smwrr_pkg::TOTAL_W-1:0]         totals [smwrr_pkg::NUM_CHANNELS];

  logic [smwrr_pkg::CH_W-1:0]            ch_q;
  logic [smwrr_pkg::PEER_W-1:0]          peer_q;
  logic [smwrr_pkg::WEIGHT_W-1:0]        weight_q;
  logic [smwrr_pkg::WEIGHT_W-1:0]        w_rd;
  logic signed [smwrr_pkg::CREDIT_W-1:0] c_rd;
  logic signed [smwrr_pkg::CREDIT_W-1:0] acc;
  logic                                  have;
  logic [smwrr_pkg::PEER_W-1:0]          best;

  logic [smwrr_pkg::ADDR_W-1:0]          rd_addr;
  logic [smwrr_pkg::TOTAL_W-1:0]         total_rd;
  logic signed [smwrr_pkg::CREDIT_W-1:0] alu_a, alu_b, alu_y;
  logic                                  active, better;
  logic                                  w_we, c_we;
  logic [smwrr_pkg::ADDR_W-1:0]          w_addr, c_addr;
  logic [smwrr_pkg::WEIGHT_W-1:0]        w_wdata;
  logic signed [smwrr_pkg::CREDIT_W-1:0] c_wdata;

  assign rd_addr  = smwrr_pkg::slot_addr(ch_q, ctl.rd_idx);
  assign total_rd = totals[ch_q];
  assign active   = w_rd != '0;
  assign better   = !have || (alu_y > acc);

  always_comb begin
    alu_a = ctl.op_scan ? c_rd : acc;
    if (ctl.finish) begin
      alu_b = ~{1'b0, total_rd} + smwrr_pkg::CREDIT_W'(1);
    end else begin
      alu_b = {{(smwrr_pkg::CREDIT_W - smwrr_pkg::WEIGHT_W){1'b0}}, w_rd};
    end
  end

  smwrr_satadd u_satadd (
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  always_comb begin
    w_we    = ctl.clear_en || ctl.wr_weight;
    w_addr  = ctl.clear_en ? ctl.clr_addr : smwrr_pkg::slot_addr(ch_q, peer_q);
    w_wdata = ctl.clear_en ? '0 : weight_q;

    c_we    = 1'b0;
    c_addr  = ctl.clr_addr;
    c_wdata = '0;
    if (ctl.clear_en) begin
      c_we = 1'b1;
    end else if (ctl.wr_weight) begin
      c_we   = weight_q == '0;
      c_addr = smwrr_pkg::slot_addr(ch_q, peer_q);
    end else if (ctl.op_scan) begin
      c_we    = ctl.proc_en && active;
      c_addr  = smwrr_pkg::slot_addr(ch_q, ctl.proc_idx);
      c_wdata = alu_y;
    end else if (ctl.finish) begin
      c_we    = have;
      c_addr  = smwrr_pkg::slot_addr(ch_q, best);
      c_wdata = alu_y;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_addr] <= w_wdata;
    end
    w_rd <= weight_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      credit_mem[c_addr] <= c_wdata;
    end
    c_rd <= credit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < smwrr_pkg::NUM_CHANNELS; i++) begin
        totals[i] <= '0;
      end
    end else if (ctl.store_total) begin
      totals[ch_q] <= alu_y[smwrr_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ch_q     <= smwrr_pkg::CH_W'(req_data.channel);
      peer_q   <= smwrr_pkg::PEER_W'(req_data.peer_index);
      weight_q <= req_data.weight;
      acc      <= '0;
      have     <= 1'b0;
      best     <= '0;
    end else if (ctl.proc_en && ctl.op_sum) begin
      acc <= alu_y;
    end else if (ctl.proc_en && ctl.op_scan && active && better) begin
      acc  <= alu_y;
      have <= 1'b1;
      best <= ctl.proc_idx;
    end
    if (ctl.done) begin
      res_data.found       <= have;
      res_data.chosen_peer <= have ? smwrr_pkg::PEER_FIELD_W'(best) : '0;
    end
  end

endmodule

/* sv/smooth_weighted_round_robin_top.sv */
// Top level of the smooth weighted round-robin picker.
// Requests arrive on req_valid/req_ready/req_data and each gives exactly one result on
// res_valid/res_ready/res_data. A write request sets one peer's weight on one channel
// (weight 0 retires the peer and clears its credit) and answers found = 0. A select
// request credits every active peer of the channel, picks the largest credit with ties
// to the lower index, and charges the channel total to the winner.
// One request is worked at a time; req_ready is high only while the sequencer is idle.
// A select walks the channel's peers one per cycle, set by the single memory read port
// and the shared saturating adder. A valid write walks the same peers, because the
// channel total is summed again over that walk; a rejected request goes from idle
// straight to posting its result. The sequencer is idle again in the same cycle that
// the result is posted. After reset the block clears the weight and credit memories
// and holds req_ready low meanwhile.
// The result sits in an output register, so the next request is accepted while an
// earlier result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds that result until the register frees.
module smooth_weighted_round_robin_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  smwrr_pkg::req_t req_data,
  output logic            res_valid,
  input  logic            res_ready,
  output smwrr_pkg::res_t res_data
);

  smwrr_pkg::ctl_t ctl;

  smwrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_data  (req_data),
    .res_ready (res_ready),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .ctl       (ctl)
  );

  smwrr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .ctl      (ctl),
    .res_data (res_data)
  );

endmodule
